@@ rtl/b2b_pkg.sv @@
// Shared types, constants and tables for the personalized BLAKE2b hash block.
`default_nettype none
package b2b_pkg;

    localparam int ROUNDS = 12;

    localparam logic [63:0] IV [0:7] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
        64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
        64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    // message schedule, one row per round
    localparam logic [3:0] SIGMA [0:11][0:15] = '{
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
          4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
        '{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
          4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3},
        '{4'd11, 4'd8, 4'd12, 4'd0, 4'd5, 4'd2, 4'd15, 4'd13,
          4'd10, 4'd14, 4'd3, 4'd6, 4'd7, 4'd1, 4'd9, 4'd4},
        '{4'd7, 4'd9, 4'd3, 4'd1, 4'd13, 4'd12, 4'd11, 4'd14,
          4'd2, 4'd6, 4'd5, 4'd10, 4'd4, 4'd0, 4'd15, 4'd8},
        '{4'd9, 4'd0, 4'd5, 4'd7, 4'd2, 4'd4, 4'd10, 4'd15,
          4'd14, 4'd1, 4'd11, 4'd12, 4'd6, 4'd8, 4'd3, 4'd13},
        '{4'd2, 4'd12, 4'd6, 4'd10, 4'd0, 4'd11, 4'd8, 4'd3,
          4'd4, 4'd13, 4'd7, 4'd5, 4'd15, 4'd14, 4'd1, 4'd9},
        '{4'd12, 4'd5, 4'd1, 4'd15, 4'd14, 4'd13, 4'd4, 4'd10,
          4'd0, 4'd7, 4'd6, 4'd3, 4'd9, 4'd2, 4'd8, 4'd11},
        '{4'd13, 4'd11, 4'd7, 4'd14, 4'd12, 4'd1, 4'd3, 4'd9,
          4'd5, 4'd0, 4'd15, 4'd4, 4'd8, 4'd6, 4'd2, 4'd10},
        '{4'd6, 4'd15, 4'd14, 4'd9, 4'd11, 4'd3, 4'd0, 4'd8,
          4'd12, 4'd2, 4'd13, 4'd7, 4'd1, 4'd4, 4'd10, 4'd5},
        '{4'd10, 4'd2, 4'd8, 4'd4, 4'd7, 4'd6, 4'd1, 4'd5,
          4'd15, 4'd11, 4'd9, 4'd14, 4'd3, 4'd12, 4'd13, 4'd0},
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
          4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
        '{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
          4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3}
    };

    localparam logic [1:0] CFG_DIGEST_LEN = 2'd0;
    localparam logic [1:0] CFG_PERS_LOW   = 2'd1;
    localparam logic [1:0] CFG_PERS_HIGH  = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic       latch;
        logic       append;
        logic       cnt_add;
        logic       v_init;
        logic       g_step;
        logic       h_upd;
        logic       last;
        logic       rd_en;
        logic [3:0] rd_addr0;
        logic [3:0] rd_addr1;
        logic [1:0] ph;
        logic [2:0] g;
        logic [2:0] out_idx;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic full;
        logic cnt_nz;
        logic accb_nz;
        logic fin;
        logic out_last;
    } t_status;

endpackage
`default_nettype wire

@@ rtl/b2b_ctrl.sv @@
// Sequencer: item handling, compression schedule and digest readout.
`default_nettype none
module b2b_ctrl import b2b_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    output logic         o_out_valid,
    input  wire logic    i_out_ready,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CHK  = 4'd1;
    localparam logic [3:0] S_APP  = 4'd2;
    localparam logic [3:0] S_POST = 4'd3;
    localparam logic [3:0] S_CNT  = 4'd4;
    localparam logic [3:0] S_INIT = 4'd5;
    localparam logic [3:0] S_MIX  = 4'd6;
    localparam logic [3:0] S_HUPD = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;

    logic [3:0] r_state, n_state;
    logic       r_last, n_last;
    logic       r_ret_app, n_ret_app;
    logic [3:0] r_round, n_round;
    logic [2:0] r_g, n_g;
    logic [1:0] r_ph, n_ph;
    logic [2:0] r_oidx, n_oidx;

    logic       mix_done;
    logic [3:0] nx_round;
    logic [2:0] nx_g;

    assign mix_done = (r_g == 3'd7) && (r_round == 4'(ROUNDS - 1));
    assign nx_g     = r_g + 3'd1;
    assign nx_round = (r_g == 3'd7) ? r_round + 4'd1 : r_round;

    always_comb begin
        n_state   = r_state;
        n_last    = r_last;
        n_ret_app = r_ret_app;
        n_round   = r_round;
        n_g       = r_g;
        n_ph      = r_ph;
        n_oidx    = r_oidx;
        o_cmd     = '0;
        o_cmd.last    = r_last;
        o_cmd.ph      = r_ph;
        o_cmd.g       = r_g;
        o_cmd.out_idx = r_oidx;
        o_in_ready    = 1'b0;
        o_out_valid   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_CHK;
                end
            end
            S_CHK: begin
                if (i_status.full && i_status.cnt_nz) begin
                    n_last    = 1'b0;
                    n_ret_app = 1'b1;
                    n_state   = S_CNT;
                end else begin
                    n_state = S_APP;
                end
            end
            S_APP: begin
                o_cmd.append = 1'b1;
                n_state      = S_POST;
            end
            S_POST: begin
                if (i_status.full && i_status.accb_nz) begin
                    n_last    = 1'b0;
                    n_ret_app = 1'b0;
                    n_state   = S_CNT;
                end else if (i_status.fin) begin
                    n_last  = 1'b1;
                    n_state = S_CNT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_CNT: begin
                o_cmd.cnt_add = 1'b1;
                n_state       = S_INIT;
            end
            S_INIT: begin
                o_cmd.v_init   = 1'b1;
                o_cmd.rd_en    = 1'b1;
                o_cmd.rd_addr0 = SIGMA[0][0];
                o_cmd.rd_addr1 = SIGMA[0][1];
                n_round        = 4'd0;
                n_g            = 3'd0;
                n_ph           = 2'd0;
                n_state        = S_MIX;
            end
            S_MIX: begin
                o_cmd.g_step = 1'b1;
                n_ph         = r_ph + 2'd1;
                if (r_ph == 2'd3) begin
                    if (mix_done) begin
                        n_state = S_HUPD;
                    end else begin
                        o_cmd.rd_en    = 1'b1;
                        o_cmd.rd_addr0 = SIGMA[nx_round][{nx_g, 1'b0}];
                        o_cmd.rd_addr1 = SIGMA[nx_round][{nx_g, 1'b1}];
                        n_round        = nx_round;
                        n_g            = nx_g;
                    end
                end
            end
            S_HUPD: begin
                o_cmd.h_upd = 1'b1;
                n_oidx      = 3'd0;
                if (r_last) begin
                    n_state = S_OUT;
                end else if (r_ret_app) begin
                    n_state = S_APP;
                end else begin
                    n_state = S_POST;
                end
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (i_status.out_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_oidx = r_oidx + 3'd1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_last    <= 1'b0;
            r_ret_app <= 1'b0;
            r_round   <= '0;
            r_g       <= '0;
            r_ph      <= '0;
            r_oidx    <= '0;
        end else begin
            r_state   <= n_state;
            r_last    <= n_last;
            r_ret_app <= n_ret_app;
            r_round   <= n_round;
            r_g       <= n_g;
            r_ph      <= n_ph;
            r_oidx    <= n_oidx;
        end
    end

endmodule
`default_nettype wire

@@ rtl/b2b_datapath.sv @@
// Datapath: config registers, block buffer, counter, chain value and G unit.
`default_nettype none
module b2b_datapath import b2b_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data,
    input  wire logic [63:0] i_message_word,
    input  wire logic [3:0]  i_byte_count,
    input  wire logic        i_final_item,
    input  wire t_cmd        i_cmd,
    output t_status          o_status,
    output logic [63:0]      o_digest_word,
    output logic [3:0]       o_digest_bytes,
    output logic             o_last_word
);

    logic [6:0]  r_dlen;
    logic [63:0] r_pl, r_ph;
    logic [63:0] r_word;
    logic [3:0]  r_cnt;
    logic        r_fin, r_busy;
    logic [63:0] r_acc;
    logic [2:0]  r_accb;
    logic [4:0]  r_words;
    logic [63:0] r_t0, r_t1;
    logic [63:0] r_h [8];
    logic [63:0] r_v [16];
    logic [63:0] r_mem [16];
    logic [63:0] r_rd0, r_rd1;
    logic [3:0]  r_ri0, r_ri1;

    // effective digest length, 1..64
    logic [6:0]  eff_len;
    assign eff_len = (r_dlen == 7'd0) ? 7'd1 : (r_dlen > 7'd64) ? 7'd64 : r_dlen;

    // input byte mask
    logic [3:0]  cnt_sat;
    logic [63:0] in_mask;
    always_comb begin
        cnt_sat = (i_byte_count > 4'd8) ? 4'd8 : i_byte_count;
        for (int i = 0; i < 8; i++) begin
            in_mask[8*i +: 8] = (4'(i) < cnt_sat) ? 8'hff : 8'h00;
        end
    end

    // byte-granular append
    logic [5:0]  sh;
    logic [6:0]  sh_sp;
    logic [63:0] comb_w, spill_w;
    logic [3:0]  total;
    logic        wr_en;
    assign sh      = {r_accb, 3'b000};
    assign sh_sp   = 7'd64 - {1'b0, sh};
    assign comb_w  = r_acc | (r_word << sh);
    assign spill_w = (r_accb == 3'd0) ? 64'd0 : (r_word >> sh_sp);
    assign total   = {1'b0, r_accb} + r_cnt;
    assign wr_en   = i_cmd.append && total[3];

    // counter increment: whole block or bytes held
    logic [7:0]  fill;
    logic [63:0] add_n, t0_sum;
    logic        t0_cy;
    assign fill  = {r_words, 3'b000} + {5'd0, r_accb};
    assign add_n = i_cmd.last ? {56'd0, fill} : 64'd128;
    assign {t0_cy, t0_sum} = {1'b0, r_t0} + {1'b0, add_n};

    // message words: unwritten tail of the block reads as zero
    logic [63:0] mx, my;
    assign mx = ({1'b0, r_ri0} < r_words) ? r_rd0 :
                ({1'b0, r_ri0} == r_words) ? r_acc : 64'd0;
    assign my = ({1'b0, r_ri1} < r_words) ? r_rd1 :
                ({1'b0, r_ri1} == r_words) ? r_acc : 64'd0;

    // G quarter step on column 0, then row rotation at the end of each G
    logic [63:0] a, b, c, d, dn, bn, cn;
    logic [63:0] t [16];
    logic [63:0] n_v [16];
    logic [1:0]  rot [4];
    logic [1:0]  col;
    always_comb begin
        a  = r_v[0];
        b  = r_v[4];
        c  = r_v[8];
        d  = r_v[12];
        dn = '0;
        bn = '0;
        cn = '0;
        for (int i = 0; i < 16; i++) t[i] = r_v[i];
        unique case (i_cmd.ph)
            2'd0: begin
                t[0] = a + b + mx;
            end
            2'd1: begin
                dn    = d ^ a;
                dn    = {dn[31:0], dn[63:32]};
                t[12] = dn;
                t[8]  = c + dn;
            end
            2'd2: begin
                bn   = b ^ c;
                bn   = {bn[23:0], bn[63:24]};
                t[4] = bn;
                t[0] = a + bn + my;
            end
            2'd3: begin
                dn    = d ^ a;
                dn    = {dn[15:0], dn[63:16]};
                cn    = c + dn;
                bn    = b ^ cn;
                t[12] = dn;
                t[8]  = cn;
                t[4]  = {bn[62:0], bn[63]};
            end
            default: begin
                t[0] = a;
            end
        endcase
        for (int r = 0; r < 4; r++) begin
            if (i_cmd.ph != 2'd3) begin
                rot[r] = 2'd0;
            end else if (i_cmd.g == 3'd3) begin
                rot[r] = 2'd1 + 2'(r);
            end else if (i_cmd.g == 3'd7) begin
                rot[r] = 2'd1 - 2'(r);
            end else begin
                rot[r] = 2'd1;
            end
        end
        col = '0;
        for (int r = 0; r < 4; r++) begin
            for (int j = 0; j < 4; j++) begin
                col          = 2'(j) + rot[r];
                n_v[4*r + j] = t[4*r + int'(col)];
            end
        end
    end

    // block buffer
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_words[3:0]] <= comb_w;
        end
        if (i_cmd.rd_en) begin
            r_rd0 <= r_mem[i_cmd.rd_addr0];
            r_rd1 <= r_mem[i_cmd.rd_addr1];
            r_ri0 <= i_cmd.rd_addr0;
            r_ri1 <= i_cmd.rd_addr1;
        end
    end

    // item latch, working vector and chain value
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_word <= i_message_word & in_mask;
            r_cnt  <= cnt_sat;
            r_fin  <= i_final_item;
        end
        if (i_cmd.v_init) begin
            for (int i = 0; i < 8; i++) begin
                r_v[i]     <= r_h[i];
                r_v[i + 8] <= IV[i];
            end
            r_v[12] <= IV[4] ^ r_t0;
            r_v[13] <= IV[5] ^ r_t1;
            r_v[14] <= i_cmd.last ? ~IV[6] : IV[6];
        end else if (i_cmd.g_step) begin
            for (int i = 0; i < 16; i++) r_v[i] <= n_v[i];
        end
        if (i_cmd.latch && !r_busy) begin
            for (int i = 0; i < 8; i++) r_h[i] <= IV[i];
            r_h[0] <= IV[0] ^ {32'd0, 8'h01, 8'h01, 9'd0, eff_len};
            r_h[6] <= IV[6] ^ r_pl;
            r_h[7] <= IV[7] ^ r_ph;
        end else if (i_cmd.h_upd) begin
            for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] ^ r_v[i] ^ r_v[i + 8];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dlen  <= 7'd64;
            r_pl    <= '0;
            r_ph    <= '0;
            r_busy  <= 1'b0;
            r_acc   <= '0;
            r_accb  <= '0;
            r_words <= '0;
            r_t0    <= '0;
            r_t1    <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_DIGEST_LEN: r_dlen <= i_cfg_data[6:0];
                    CFG_PERS_LOW:   r_pl   <= i_cfg_data;
                    CFG_PERS_HIGH:  r_ph   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.latch) begin
                r_busy <= 1'b1;
            end
            if (i_cmd.append) begin
                if (total[3]) begin
                    r_words <= r_words + 5'd1;
                    r_acc   <= spill_w;
                    r_accb  <= total[2:0];
                end else begin
                    r_acc  <= comb_w;
                    r_accb <= total[2:0];
                end
            end
            if (i_cmd.cnt_add) begin
                r_t0 <= t0_sum;
                r_t1 <= r_t1 + {63'd0, t0_cy};
            end
            if (i_cmd.h_upd) begin
                r_words <= '0;
                if (i_cmd.last) begin
                    r_busy <= 1'b0;
                    r_acc  <= '0;
                    r_accb <= '0;
                    r_t0   <= '0;
                    r_t1   <= '0;
                end
            end
        end
    end

    // digest readout
    logic [6:0] len_m1;
    logic [6:0] done_b;
    assign len_m1 = eff_len - 7'd1;
    assign done_b = {1'b0, i_cmd.out_idx, 3'b000};

    assign o_digest_word  = r_h[i_cmd.out_idx];
    assign o_last_word    = (i_cmd.out_idx == len_m1[5:3]);
    assign o_digest_bytes = o_last_word ? 4'(eff_len - done_b) : 4'd8;

    assign o_status.full     = r_words[4];
    assign o_status.cnt_nz   = (r_cnt != 4'd0);
    assign o_status.accb_nz  = (r_accb != 3'd0);
    assign o_status.fin      = r_fin;
    assign o_status.out_last = o_last_word;

endmodule
`default_nettype wire

@@ rtl/blake2b_personalized_hash.sv @@
// Top level of the personalized, unkeyed BLAKE2b hash block.
//
//  channel  | direction | handshake                    | payload
//  ---------+-----------+------------------------------+---------------------------------
//  s_axis   | in        | s_axis_tvalid/s_axis_tready  | tdata: message_word, byte_count;
//           |           |                              | tlast: final_item
//  m_axis   | out       | m_axis_tvalid/m_axis_tready  | tdata: digest_word, digest_bytes;
//           |           |                              | tlast: last_word
//  cfg      | in        | i_cfg_valid/o_cfg_ready      | i_cfg_index, i_cfg_data
//
// Without a compression an item passes accept, check, append and post check.
// A compression runs counter, init, 12 rounds x 8 G x 4 quarter steps through
// the single G unit, and chain update; no new item is taken while it runs, so
// compressions set the rate over a full 16-word block.
// The final item ends with the last-block compression, then one cycle per digest word
// while m_axis_tready is high; s_axis_tready stays low until the last
// digest transfer. Synchronous active-low reset; config is always ready.
`default_nettype none
module blake2b_personalized_hash import b2b_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [71:0] s_axis_tdata,   // [63:0] message_word, [67:64] byte_count, pad
    input  wire logic        s_axis_tlast,   // final_item
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [71:0]      m_axis_tdata,   // [63:0] digest_word, [67:64] digest_bytes, pad
    output logic             m_axis_tlast,   // last_word
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data
);

    t_cmd        cmd;
    t_status     status;
    logic [63:0] digest_word;
    logic [3:0]  digest_bytes;

    assign o_cfg_ready = 1'b1;

    b2b_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    b2b_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_valid & o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_message_word (s_axis_tdata[63:0]),
        .i_byte_count   (s_axis_tdata[67:64]),
        .i_final_item   (s_axis_tlast),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_digest_word  (digest_word),
        .o_digest_bytes (digest_bytes),
        .o_last_word    (m_axis_tlast)
    );

    assign m_axis_tdata = {4'd0, digest_bytes, digest_word};

endmodule
`default_nettype wire

@@ rtl/b2b_checker.sv @@
// Port-level checks for the hash block, bound to the top level.
`default_nettype none
module b2b_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [71:0] m_axis_tdata,
    input wire logic        m_axis_tlast
);

    // a stalled digest word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast))
        else $error("digest word changed while stalled");

    // no new message word while digest is pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready during digest readout");

    // only the last digest word may be short
    a_full_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[67:64] == 4'd8)
        else $error("short digest word before last");

    // byte count in range, pad zero
    a_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[67:64] != 4'd0 && !(m_axis_tdata[67:64] > 4'd8)
            && m_axis_tdata[71:68] == 4'd0)
        else $error("digest byte count out of range");

endmodule

bind blake2b_personalized_hash b2b_checker u_b2b_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

@@ test/testbench.sv @@
// Self-checking testbench for the personalized BLAKE2b hash block: directed and random messages.
`default_nettype none
module testbench;
    import b2b_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    // one expected digest word
    typedef struct {
        logic [63:0] word;
        logic [3:0]  nbytes;
        logic        last;
    } t_digest_exp;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [63:0] i_cfg_data = '0;

    blake2b_personalized_hash dut (.*);

    // predictor: register copies and hash state
    logic [6:0]   reg_dlen = 7'd64;
    logic [63:0]  reg_pers_lo = '0;
    logic [63:0]  reg_pers_hi = '0;
    logic [63:0]  chain [8];
    logic [127:0] msg_bytes;
    logic [63:0]  blk [16];
    int unsigned  blk_fill;
    bit           in_message;
    logic [63:0]  wv [16];

    t_digest_exp digest_q [$];
    int          errors = 0;
    int          words_sent = 0;
    int          cycles = 0;
    bit          no_gaps = 1'b0;
    int          hold_req = 0;     // bumped by a test to force a long receiver stall
    int          hold_seen = 0;
    int          hold_left = 0;
    int          stall_left = 0;

    initial forever #5 i_clk = ~i_clk;

    function automatic logic [63:0] rotr64(logic [63:0] w, int c);
        return (w >> c) | (w << (64 - c));
    endfunction

    function automatic int unsigned taken_len();
        if (reg_dlen == 0) return 1;
        if (reg_dlen > 64) return 64;
        return reg_dlen;
    endfunction

    function automatic void g_mix(int a, int b, int c, int d, logic [63:0] x, logic [63:0] y);
        wv[a] = wv[a] + wv[b] + x;
        wv[d] = rotr64(wv[d] ^ wv[a], 32);
        wv[c] = wv[c] + wv[d];
        wv[b] = rotr64(wv[b] ^ wv[c], 24);
        wv[a] = wv[a] + wv[b] + y;
        wv[d] = rotr64(wv[d] ^ wv[a], 16);
        wv[c] = wv[c] + wv[d];
        wv[b] = rotr64(wv[b] ^ wv[c], 63);
    endfunction

    function automatic void compress_block(bit last_blk);
        for (int i = 0; i < 8; i++) begin
            wv[i] = chain[i];
            wv[i+8] = IV[i];
        end
        wv[12] ^= msg_bytes[63:0];
        wv[13] ^= msg_bytes[127:64];
        if (last_blk) wv[14] = ~wv[14];
        for (int r = 0; r < ROUNDS; r++) begin
            g_mix(0, 4, 8, 12, blk[SIGMA[r][0]], blk[SIGMA[r][1]]);
            g_mix(1, 5, 9, 13, blk[SIGMA[r][2]], blk[SIGMA[r][3]]);
            g_mix(2, 6, 10, 14, blk[SIGMA[r][4]], blk[SIGMA[r][5]]);
            g_mix(3, 7, 11, 15, blk[SIGMA[r][6]], blk[SIGMA[r][7]]);
            g_mix(0, 5, 10, 15, blk[SIGMA[r][8]], blk[SIGMA[r][9]]);
            g_mix(1, 6, 11, 12, blk[SIGMA[r][10]], blk[SIGMA[r][11]]);
            g_mix(2, 7, 8, 13, blk[SIGMA[r][12]], blk[SIGMA[r][13]]);
            g_mix(3, 4, 9, 14, blk[SIGMA[r][14]], blk[SIGMA[r][15]]);
        end
        for (int i = 0; i < 8; i++) chain[i] ^= wv[i] ^ wv[i+8];
    endfunction

    function automatic void clear_block();
        for (int i = 0; i < 16; i++) blk[i] = '0;
        blk_fill = 0;
    endfunction

    // absorb one accepted word; on the final word queue the digest words
    function automatic void hash_absorb(logic [63:0] word, logic [3:0] cnt, logic fin);
        int unsigned n, len, nw;
        t_digest_exp e;
        if (!in_message) begin
            for (int i = 0; i < 8; i++) chain[i] = IV[i];
            chain[0] ^= 64'(taken_len()) | 64'h01010000;
            chain[6] ^= reg_pers_lo;
            chain[7] ^= reg_pers_hi;
            msg_bytes = '0;
            clear_block();
            in_message = 1'b1;
        end
        n = (cnt > 8) ? 8 : cnt;
        for (int i = 0; i < n; i++) begin
            if (blk_fill >= 128) begin
                msg_bytes += 128;
                compress_block(1'b0);
                clear_block();
            end
            blk[blk_fill >> 3] |= 64'(word[8*i +: 8]) << (8 * (blk_fill & 7));
            blk_fill++;
        end
        if (!fin) return;
        msg_bytes += blk_fill;
        compress_block(1'b1);
        len = taken_len();
        nw = (len + 7) / 8;
        for (int i = 0; i < nw; i++) begin
            e.word = chain[i];
            e.nbytes = (i + 1 == nw) ? 4'(len - 8 * i) : 4'd8;
            e.last = (i + 1 == nw);
            digest_q.push_back(e);
        end
        in_message = 1'b0;
    endfunction

    // sender: one word, random gap first unless gaps are off; called at a clock edge
    task automatic send_word(logic [63:0] word, logic [3:0] cnt, logic fin);
        int gap, r;
        r = $urandom_range(0, 99);
        gap = no_gaps ? 0 : (r < 55) ? 0 : (r < 92) ? $urandom_range(1, 3)
                                                    : $urandom_range(10, 40);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'b0, cnt, word};
        s_axis_tlast <= fin;
        do @(posedge i_clk); while (!s_axis_tready);
        hash_absorb(word, cnt, fin);
        words_sent++;
    endtask

    task automatic idle_sender();
        s_axis_tvalid <= 1'b0;
        s_axis_tlast <= 1'b0;
    endtask

    // wait until every queued digest word has been seen, then let the block settle
    task automatic drain();
        idle_sender();
        while (digest_q.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [63:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_DIGEST_LEN: reg_dlen = val[6:0];
            CFG_PERS_LOW:   reg_pers_lo = val;
            CFG_PERS_HIGH:  reg_pers_hi = val;
            default: ;
        endcase
    endtask

    task automatic random_word(output logic [63:0] w);
        w = {$urandom, $urandom};
    endtask

    // message of nw words with random content; short non-final words now and then
    task automatic send_message(int nw);
        logic [63:0] w;
        logic [3:0]  c;
        for (int i = 0; i < nw; i++) begin
            random_word(w);
            if (i == nw - 1) c = 4'($urandom_range(0, 15));
            else if ($urandom_range(0, 9) == 0) c = 4'($urandom_range(0, 15));
            else c = 4'd8;
            send_word(w, c, i == nw - 1);
        end
    endtask

    // empty message, saturated count, short non-final word, field extremes
    task automatic test_edge_words();
        send_word(64'h0, 4'd0, 1'b1);
        send_word('1, 4'd15, 1'b1);
        send_word(64'h0123456789abcdef, 4'd3, 1'b0);
        send_word('1, 4'd5, 1'b1);
        send_word(64'h0, 4'd8, 1'b1);
        drain();
    endtask

    // digest length extremes, including out-of-range values, and personal strings
    task automatic test_config_extremes();
        write_reg(CFG_DIGEST_LEN, 64'd1);
        write_reg(CFG_PERS_LOW, '1);
        write_reg(CFG_PERS_HIGH, '1);
        send_word(64'h61, 4'd1, 1'b1);
        drain();
        write_reg(CFG_DIGEST_LEN, 64'd0);
        write_reg(CFG_PERS_LOW, 64'h0);
        send_word('1, 4'd8, 1'b1);
        drain();
        write_reg(CFG_DIGEST_LEN, 64'd127);
        send_word(64'h0, 4'd7, 1'b1);
        drain();
        write_reg(CFG_DIGEST_LEN, 64'd65);
        write_reg(CFG_PERS_HIGH, 64'h0);
        send_word(64'h5a5a5a5a5a5a5a5a, 4'd8, 1'b1);
        drain();
        write_reg(CFG_DIGEST_LEN, 64'd64);
    endtask

    // exactly one full block, then one word past it, with gaps off
    task automatic test_block_boundary();
        logic [63:0] w;
        no_gaps = 1'b1;
        for (int i = 0; i < 16; i++) begin
            random_word(w);
            send_word(w, 4'd8, i == 15);
        end
        drain();
        for (int i = 0; i < 17; i++) begin
            random_word(w);
            send_word(w, 4'd8, i == 16);
        end
        no_gaps = 1'b0;
        drain();
    endtask

    // receiver holds off a long time while messages keep coming
    task automatic test_backpressure();
        write_reg(CFG_DIGEST_LEN, 64'd64);
        hold_req <= hold_req + 1;
        no_gaps = 1'b1;
        for (int m = 0; m < 3; m++) send_message($urandom_range(1, 4));
        no_gaps = 1'b0;
        drain();
    endtask

    task automatic test_random_messages();
        int target, nw;
        logic [63:0] v;
        target = words_sent + 75;
        while (words_sent < target) begin
            if ($urandom_range(0, 2) == 0) begin
                drain();
                random_word(v);
                write_reg(CFG_DIGEST_LEN, 64'($urandom_range(0, 127)));
                if ($urandom_range(0, 1)) write_reg(CFG_PERS_LOW, v);
                random_word(v);
                if ($urandom_range(0, 1)) write_reg(CFG_PERS_HIGH, v);
            end
            no_gaps = ($urandom_range(0, 3) == 0);
            nw = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 34) : $urandom_range(1, 8);
            send_message(nw);
        end
        no_gaps = 1'b0;
        drain();
    endtask

    // receiver: random ready with short and long stalls, checks every digest transfer
    always @(posedge i_clk) begin
        t_digest_exp e;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (digest_q.size() == 0) begin
                    $error("digest transfer with nothing expected: %h", m_axis_tdata);
                    errors++;
                end else begin
                    e = digest_q.pop_front();
                    if (m_axis_tdata[63:0] !== e.word) begin
                        $error("digest_word expected %h got %h", e.word, m_axis_tdata[63:0]);
                        errors++;
                    end
                    if (m_axis_tdata[67:64] !== e.nbytes) begin
                        $error("digest_bytes expected %0d got %0d", e.nbytes,
                               m_axis_tdata[67:64]);
                        errors++;
                    end
                    if (m_axis_tlast !== e.last) begin
                        $error("last_word expected %0d got %0d", e.last, m_axis_tlast);
                        errors++;
                    end
                end
            end
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = 500;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if ($urandom_range(0, 60) == 0) begin
                stall_left = $urandom_range(15, 60);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 9) < 7);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_edge_words();
        test_config_extremes();
        test_block_boundary();
        test_backpressure();
        test_random_messages();
        if (digest_q.size() != 0) begin
            $error("%0d digest words never arrived", digest_q.size());
            errors++;
        end
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
`default_nettype wire
